>>> hdl/shp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shp_pkg
// Shared constants and codes of the 3x3 Laplacian sharpening unit.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int CHAN_W          = 8;
  localparam int PORT_CHANNELS   = 3;
  localparam int POS_W           = 12;
  localparam int CFG_DATA_W      = 13;
  localparam int CFG_INDEX_W     = 2;
  localparam int COUNT_W         = 2;
  localparam int SUM_W           = 12;

  localparam int MAX_WIDTH_DEF      = 4096;
  localparam int PIXEL_CHANNELS_DEF = 3;
  localparam int MAX_HEIGHT         = 4096;
  localparam int MIN_DIM            = 3;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [COUNT_W-1:0]    COUNT_RESET  = 2'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_index_t;

endpackage
`default_nettype wire

>>> hdl/shp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/shp_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shp_lane
// One channel of the sharpening kernel: 5*centre minus the four direct
// neighbors, saturated to 0..255, or zero when the lane is not active.
// ----------------------------------------------------------------------------
module shp_lane (
  input  wire  [shp_pkg::CHAN_W-1:0] centre,
  input  wire  [shp_pkg::CHAN_W-1:0] up,
  input  wire  [shp_pkg::CHAN_W-1:0] down,
  input  wire  [shp_pkg::CHAN_W-1:0] left,
  input  wire  [shp_pkg::CHAN_W-1:0] right,
  input  wire                        active,
  output logic [shp_pkg::CHAN_W-1:0] sharp
);

  // range -1020..1275, two's complement in SUM_W bits
  logic [shp_pkg::SUM_W-1:0] sum;

  always_comb begin
    sum = {2'b00, centre, 2'b00} + shp_pkg::SUM_W'(centre)
        - shp_pkg::SUM_W'(up) - shp_pkg::SUM_W'(down)
        - shp_pkg::SUM_W'(left) - shp_pkg::SUM_W'(right);
    if (!active || sum[shp_pkg::SUM_W-1]) begin
      sharp = '0;
    end else if (sum[shp_pkg::SUM_W-2:shp_pkg::CHAN_W] != '0) begin
      sharp = '1;
    end else begin
      sharp = sum[shp_pkg::CHAN_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> hdl/sharpen_3x3_laplacian_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sharpen_3x3_laplacian_unit
// 3x3 Laplacian sharpening over a raster pixel stream, one lane per channel.
//
// Pixels enter on the in_valid/in_ready channel in raster order, one request
// per pixel. The unit keeps its own row and column from frame_width and
// frame_height. For each interior centre pixel it returns one request on the
// out channel with the centre's row and column and the sharpened channels;
// border pixels produce nothing. The result for centre (r-1, c-1) is formed
// when the pixel at (r, c) arrives.
// Throughput is one pixel per clock while the output is not stalled; the two
// line buffer RAMs are read once and written once per pixel. A pixel's result
// passes the RAM read, then the kernel and output register. When out_ready
// is low with a result held, in_ready drops and the whole pipe stalls; nothing
// is lost. The user must make configuration writes (cfg_valid/cfg_ready,
// always ready) only while the unit is idle; the unit does not enforce it.
// Synchronous reset clears position counters, window and output valid and
// loads 640 x 480, three channels. Line buffers are not cleared; the first two
// rows of a frame fill them before any result depends on them.
// ----------------------------------------------------------------------------
module sharpen_3x3_laplacian_unit #(
  parameter int MAX_WIDTH      = shp_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_CHANNELS = shp_pkg::PIXEL_CHANNELS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [shp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [shp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [shp_pkg::CHAN_W-1:0]       pixel_ch0,
  input  wire  [shp_pkg::CHAN_W-1:0]       pixel_ch1,
  input  wire  [shp_pkg::CHAN_W-1:0]       pixel_ch2,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [shp_pkg::POS_W-1:0]        centre_row,
  output logic [shp_pkg::POS_W-1:0]        centre_col,
  output logic [shp_pkg::CHAN_W-1:0]       sharp_ch0,
  output logic [shp_pkg::CHAN_W-1:0]       sharp_ch1,
  output logic [shp_pkg::CHAN_W-1:0]       sharp_ch2,
  output logic                             frame_done
);

  localparam int CW    = shp_pkg::CHAN_W;
  localparam int PW    = shp_pkg::POS_W;
  localparam int LANES = (PIXEL_CHANNELS < shp_pkg::PORT_CHANNELS) ?
                         PIXEL_CHANNELS : shp_pkg::PORT_CHANNELS;
  localparam int LW    = LANES * CW;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WL_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WL_W > shp_pkg::CFG_DATA_W) ? WL_W : shp_pkg::CFG_DATA_W;
  localparam int HW    = shp_pkg::CFG_DATA_W;

  // configuration
  logic [shp_pkg::CFG_DATA_W-1:0] frame_width;
  logic [shp_pkg::CFG_DATA_W-1:0] frame_height;
  logic [shp_pkg::COUNT_W-1:0]    channel_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= shp_pkg::WIDTH_RESET;
      frame_height  <= shp_pkg::HEIGHT_RESET;
      channel_count <= shp_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (shp_pkg::cfg_index_t'(cfg_index))
        shp_pkg::CFG_FRAME_WIDTH:   frame_width   <= cfg_data;
        shp_pkg::CFG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        shp_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[shp_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CMP_W-1:0]             used_w;
  logic [HW-1:0]                used_h;
  logic [shp_pkg::COUNT_W-1:0]  act_count;

  always_comb begin
    used_w = CMP_W'(frame_width);
    if (frame_width < shp_pkg::CFG_DATA_W'(shp_pkg::MIN_DIM)) begin
      used_w = CMP_W'(shp_pkg::MIN_DIM);
    end else if (CMP_W'(frame_width) > CMP_W'(MAX_WIDTH)) begin
      used_w = CMP_W'(MAX_WIDTH);
    end
    used_h = frame_height;
    if (frame_height < HW'(shp_pkg::MIN_DIM)) begin
      used_h = HW'(shp_pkg::MIN_DIM);
    end else if (frame_height > HW'(shp_pkg::MAX_HEIGHT)) begin
      used_h = HW'(shp_pkg::MAX_HEIGHT);
    end
    act_count = (channel_count == '0) ? shp_pkg::COUNT_W'(1) : channel_count;
    if (32'(act_count) > PIXEL_CHANNELS) begin
      act_count = shp_pkg::COUNT_W'(PIXEL_CHANNELS);
    end
  end

  // position tracking
  logic [PW-1:0]    row;
  logic [COL_W-1:0] col;
  logic [PW-1:0]    row_next;
  logic [COL_W-1:0] col_next;
  logic [PW-1:0]    r_cur;
  logic [COL_W-1:0] c_cur;
  logic [COL_W-1:0] c_less;
  logic [HW-1:0]    row_adv;
  logic [HW-1:0]    r_inc;
  logic [CMP_W-1:0] c_inc;
  logic             col_wrap;
  logic             emit_cur;
  logic             done_cur;

  logic en;
  logic accept;

  assign en     = !out_valid || out_ready;
  assign in_ready = en;
  assign accept = in_valid && en;

  always_comb begin
    col_wrap = CMP_W'(col) >= used_w;
    row_adv  = col_wrap ? ({1'b0, row} + HW'(1)) : {1'b0, row};
    r_cur    = (row_adv >= used_h) ? '0 : row_adv[PW-1:0];
    c_cur    = col_wrap ? '0 : col;
    c_inc    = CMP_W'(c_cur) + CMP_W'(1);
    r_inc    = {1'b0, r_cur} + HW'(1);
    if (c_inc >= used_w) begin
      col_next = '0;
      row_next = (r_inc >= used_h) ? '0 : r_inc[PW-1:0];
    end else begin
      col_next = c_inc[COL_W-1:0];
      row_next = r_cur;
    end
    c_less   = c_cur - COL_W'(1);
    emit_cur = (r_cur >= PW'(2)) && (c_cur >= COL_W'(2));
    done_cur = ({1'b0, r_cur} == used_h - HW'(1))
            && (CMP_W'(c_cur) == used_w - CMP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

  // input pixel packing
  logic [CW-1:0] port_px [shp_pkg::PORT_CHANNELS];
  logic [LW-1:0] px_in;

  assign port_px[0] = pixel_ch0;
  assign port_px[1] = pixel_ch1;
  assign port_px[2] = pixel_ch2;

  for (genvar k = 0; k < LANES; k++) begin : g_pack
    assign px_in[k*CW +: CW] = port_px[k];
  end

  // stage 1: line buffer read data and item metadata
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_done;
  logic [PW-1:0]    s1_row;
  logic [PW-1:0]    s1_col;
  logic [COL_W-1:0] s1_addr;
  logic [LW-1:0]    s1_px;
  logic [LW-1:0]    up_q;
  logic [LW-1:0]    mid_q;
  logic             line_we;

  assign line_we = en && s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (accept) begin
      s1_emit <= emit_cur;
      s1_done <= done_cur;
      s1_row  <= r_cur - PW'(1);
      s1_col  <= PW'(c_less);
      s1_addr <= c_cur;
      s1_px   <= px_in;
    end
  end

  shp_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_older_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_addr),
    .wdata (mid_q),
    .re    (accept),
    .raddr (c_cur),
    .rdata (up_q)
  );

  shp_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_newer_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_addr),
    .wdata (s1_px),
    .re    (accept),
    .raddr (c_cur),
    .rdata (mid_q)
  );

  // window history: previous two middle-row pixels, previous top and bottom
  logic [LW-1:0] mid_d1;
  logic [LW-1:0] mid_d2;
  logic [LW-1:0] up_d1;
  logic [LW-1:0] px_d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_d1 <= '0;
      mid_d2 <= '0;
      up_d1  <= '0;
      px_d1  <= '0;
    end else if (line_we) begin
      mid_d1 <= mid_q;
      mid_d2 <= mid_d1;
      up_d1  <= up_q;
      px_d1  <= s1_px;
    end
  end

  // channel lanes
  logic [CW-1:0] lane_res [shp_pkg::PORT_CHANNELS];

  for (genvar k = 0; k < shp_pkg::PORT_CHANNELS; k++) begin : g_lane
    if (k < LANES) begin : g_on
      shp_lane u_lane (
        .centre (mid_d1[k*CW +: CW]),
        .up     (up_d1[k*CW +: CW]),
        .down   (px_d1[k*CW +: CW]),
        .left   (mid_d2[k*CW +: CW]),
        .right  (mid_q[k*CW +: CW]),
        .active (shp_pkg::COUNT_W'(k) < act_count),
        .sharp  (lane_res[k])
      );
    end else begin : g_off
      assign lane_res[k] = '0;
    end
  end

  // merge into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid && s1_emit;
    end
    if (en && s1_valid && s1_emit) begin
      centre_row <= s1_row;
      centre_col <= s1_col;
      sharp_ch0  <= lane_res[0];
      sharp_ch1  <= lane_res[1];
      sharp_ch2  <= lane_res[2];
      frame_done <= s1_done;
    end
  end

  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_emit))
    else $error("result raised without an emitting item in stage 1");

  a_done_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> centre_row == PW'(used_h - HW'(2)))
    else $error("frame_done on a row other than the last interior row");

  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && act_count == shp_pkg::COUNT_W'(1) |-> sharp_ch1 == '0 && sharp_ch2 == '0)
    else $error("inactive channel nonzero in one-channel mode");

  a_row_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> centre_row != '0)
    else $error("result emitted for the top border row");

endmodule
`default_nettype wire

>>> test/tb_sharpen_3x3_laplacian_unit.sv
// ----------------------------------------------------------------------------
// tb_sharpen_3x3_laplacian_unit
// Self-checking bench for the 3x3 Laplacian sharpening unit. Pixel frames are
// streamed in raster order, mostly under random gaps and output back-pressure.
// A line-buffer predictor inside the bench forms the expected sharpened
// result for every interior pixel. Each returned request is checked field by
// field. Directed tests cover kernel saturation, register clamping, channel
// counts, mid-frame geometry changes and wide and tall frames. Random
// frames with occasional mid-frame disturbances follow.
// ----------------------------------------------------------------------------
module tb_sharpen_3x3_laplacian_unit;

  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PIXELS = 450;
  localparam int WIDE_ROW      = 64;
  localparam int TALL_COLUMN   = 64;
  localparam logic [shp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {PIX_NOISE, PIX_BINARY, PIX_DARK} pixel_mode_t;

  typedef struct packed {
    logic [shp_pkg::POS_W-1:0]  row;
    logic [shp_pkg::POS_W-1:0]  col;
    logic [shp_pkg::CHAN_W-1:0] ch0;
    logic [shp_pkg::CHAN_W-1:0] ch1;
    logic [shp_pkg::CHAN_W-1:0] ch2;
    logic                       done;
  } sharp_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [shp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [shp_pkg::CHAN_W-1:0]      pixel_ch0 = '0;
  logic [shp_pkg::CHAN_W-1:0]      pixel_ch1 = '0;
  logic [shp_pkg::CHAN_W-1:0]      pixel_ch2 = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [shp_pkg::POS_W-1:0]       centre_row;
  logic [shp_pkg::POS_W-1:0]       centre_col;
  logic [shp_pkg::CHAN_W-1:0]      sharp_ch0;
  logic [shp_pkg::CHAN_W-1:0]      sharp_ch1;
  logic [shp_pkg::CHAN_W-1:0]      sharp_ch2;
  logic                            frame_done;

  // predictor state
  logic [shp_pkg::CFG_DATA_W-1:0] width_reg = shp_pkg::WIDTH_RESET;
  logic [shp_pkg::CFG_DATA_W-1:0] height_reg = shp_pkg::HEIGHT_RESET;
  logic [shp_pkg::COUNT_W-1:0]    count_reg = shp_pkg::COUNT_RESET;
  logic [23:0]                    older_row [shp_pkg::MAX_WIDTH_DEF];
  logic [23:0]                    newer_row [shp_pkg::MAX_WIDTH_DEF];
  logic [23:0]                    win [9] = '{default: '0};
  int unsigned                    row_pos = 0;
  int unsigned                    col_pos = 0;

  sharp_result_t expected_sharp[$];
  int            mismatch_count = 0;
  int            stall_cycles = 0;
  logic          steady = 1'b0;

  sharpen_3x3_laplacian_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_ch0  (pixel_ch0),
    .pixel_ch1  (pixel_ch1),
    .pixel_ch2  (pixel_ch2),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .centre_row (centre_row),
    .centre_col (centre_col),
    .sharp_ch0  (sharp_ch0),
    .sharp_ch1  (sharp_ch1),
    .sharp_ch2  (sharp_ch2),
    .frame_done (frame_done)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR: %s", what);
  endtask

  function automatic int unsigned clamp_dim(
      input logic [shp_pkg::CFG_DATA_W-1:0] value, input int unsigned upper);
    if (value < shp_pkg::MIN_DIM) return shp_pkg::MIN_DIM;
    if (value > upper) return upper;
    return 32'(value);
  endfunction

  function automatic logic [23:0] random_pixel(input pixel_mode_t mode);
    logic [23:0] px;
    px = 24'($urandom);
    case (mode)
      PIX_BINARY: begin
        for (int k = 0; k < 3; k++) px[8*k +: 8] = px[8*k] ? 8'hFF : 8'h00;
      end
      PIX_DARK: begin
        px = px & 24'h1F1F1F;
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic predict_sharpened(input logic [23:0] px);
    int unsigned   w, h, r, c, active;
    logic [23:0]   up, mid, lanes;
    int            v;
    sharp_result_t res;
    begin
      w = clamp_dim(width_reg, shp_pkg::MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, shp_pkg::MAX_HEIGHT);
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      up = older_row[c];
      mid = newer_row[c];
      older_row[c] = mid;
      newer_row[c] = px;
      for (int k = 0; k < 3; k++) begin
        win[3*k] = win[3*k+1];
        win[3*k+1] = win[3*k+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = px;
      if (r >= 2 && c >= 2) begin
        active = (count_reg == 0) ? 1 : count_reg;
        lanes = '0;
        for (int k = 0; k < 3; k++) begin
          if (k < active) begin
            v = 5 * int'(win[4][8*k +: 8]) - int'(win[1][8*k +: 8])
              - int'(win[7][8*k +: 8]) - int'(win[3][8*k +: 8])
              - int'(win[5][8*k +: 8]);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            lanes[8*k +: 8] = 8'(v);
          end
        end
        res.row = 12'(r - 1);
        res.col = 12'(c - 1);
        res.ch0 = lanes[7:0];
        res.ch1 = lanes[15:8];
        res.ch2 = lanes[23:16];
        res.done = (r == h - 1) && (c == w - 1);
        expected_sharp.push_back(res);
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
      end
    end
  endtask

  task automatic send_pixel(input logic [23:0] px);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_ch0 <= px[7:0];
    pixel_ch1 <= px[15:8];
    pixel_ch2 <= px[23:16];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sharpened(px);
  endtask

  task automatic write_reg(input logic [shp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [shp_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      shp_pkg::CFG_FRAME_WIDTH:   width_reg = data;
      shp_pkg::CFG_FRAME_HEIGHT:  height_reg = data;
      shp_pkg::CFG_CHANNEL_COUNT: count_reg = data[shp_pkg::COUNT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain outstanding requests, then cover pixels that produce no result
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_sharp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_frame(input pixel_mode_t mode);
    do begin
      send_pixel(random_pixel(mode));
    end while (row_pos != 0 || col_pos != 0);
  endtask

  task automatic test_kernel_extremes();
    logic [7:0]  centre [3];
    logic [7:0]  around [3];
    logic [23:0] px;
    begin
      centre = '{8'hFF, 8'h00, 8'd90};
      around = '{8'h00, 8'hFF, 8'd100};
      write_reg(shp_pkg::CFG_FRAME_WIDTH, 13'd3);
      write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'd3);
      write_reg(shp_pkg::CFG_CHANNEL_COUNT, 13'd3);
      for (int f = 0; f < 3; f++) begin
        for (int p = 0; p < 9; p++) begin
          px = random_pixel(PIX_NOISE);
          if (p == 4) px[15:0] = {around[f], centre[f]};
          else if (p % 2 == 1) px[15:0] = {centre[f], around[f]};
          send_pixel(px);
        end
      end
      settle();
    end
  endtask

  task automatic test_register_clamps();
    write_reg(shp_pkg::CFG_FRAME_WIDTH, 13'd1);
    write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'd2);
    write_reg(shp_pkg::CFG_CHANNEL_COUNT, 13'd0);
    write_reg(CFG_UNUSED, 13'h1FFF);
    send_frame(PIX_NOISE);
    settle();
    write_reg(shp_pkg::CFG_FRAME_WIDTH, 13'd0);
    write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'd0);
    write_reg(shp_pkg::CFG_CHANNEL_COUNT, 13'h1FFE);
    send_frame(PIX_BINARY);
    settle();
  endtask

  task automatic test_channel_counts();
    write_reg(shp_pkg::CFG_FRAME_WIDTH, 13'd5);
    write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'd3);
    for (int n = 0; n < 4; n++) begin
      write_reg(shp_pkg::CFG_CHANNEL_COUNT, 13'(n));
      send_frame(PIX_NOISE);
      send_frame(PIX_BINARY);
      settle();
    end
  endtask

  task automatic test_midframe_geometry();
    write_reg(shp_pkg::CFG_FRAME_WIDTH, 13'd6);
    write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'd5);
    write_reg(shp_pkg::CFG_CHANNEL_COUNT, 13'd3);
    repeat (17) send_pixel(random_pixel(PIX_NOISE));
    settle();
    write_reg(shp_pkg::CFG_FRAME_WIDTH, 13'd4);
    repeat (6) send_pixel(random_pixel(PIX_NOISE));
    settle();
    write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'd3);
    repeat (5) send_pixel(random_pixel(PIX_BINARY));
    settle();
    write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'd7);
    send_frame(PIX_NOISE);
    settle();
  endtask

  task automatic test_widest_rows();
    steady = 1'b1;
    write_reg(shp_pkg::CFG_FRAME_WIDTH, 13'(WIDE_ROW));
    write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'd3);
    repeat (2 * WIDE_ROW + 20) send_pixel(random_pixel(PIX_NOISE));
    settle();
    send_frame(PIX_NOISE);
    settle();
    steady = 1'b0;
  endtask

  task automatic test_tallest_column();
    write_reg(shp_pkg::CFG_FRAME_WIDTH, 13'd3);
    write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'(TALL_COLUMN));
    repeat (100) send_pixel(random_pixel(PIX_NOISE));
    settle();
    send_frame(PIX_DARK);
    settle();
  endtask

  task automatic test_random_frames();
    int          sent, frame_sent, disturb_at;
    int unsigned w, h;
    pixel_mode_t mode;
    begin
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
        settle();
        write_reg(shp_pkg::CFG_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ?
                  13'($urandom_range(0, 2)) : 13'($urandom_range(3, 12)));
        write_reg(shp_pkg::CFG_FRAME_HEIGHT, ($urandom_range(0, 9) == 0) ?
                  13'($urandom_range(0, 2)) : 13'($urandom_range(3, 8)));
        write_reg(shp_pkg::CFG_CHANNEL_COUNT,
                  {11'($urandom), 2'($urandom_range(0, 3))});
        w = clamp_dim(width_reg, shp_pkg::MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, shp_pkg::MAX_HEIGHT);
        disturb_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, w * h - 1)) : -1;
        mode = pixel_mode_t'($urandom_range(0, 2));
        frame_sent = 0;
        do begin
          if (frame_sent == disturb_at) begin
            settle();
            // width may only shrink mid-frame
            case ($urandom_range(0, 2))
              0: write_reg(shp_pkg::CFG_CHANNEL_COUNT, 13'($urandom_range(0, 3)));
              1: write_reg(shp_pkg::CFG_FRAME_HEIGHT, 13'($urandom_range(0, 8)));
              default: write_reg(shp_pkg::CFG_FRAME_WIDTH, 13'($urandom_range(0, w)));
            endcase
          end
          send_pixel(random_pixel(mode));
          frame_sent++;
          sent++;
        end while (row_pos != 0 || col_pos != 0);
      end
      settle();
    end
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin : check_sharp
    sharp_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_sharp.size() == 0) begin
        report_mismatch($sformatf("unexpected request row %0d col %0d",
                                  centre_row, centre_col));
      end else begin
        want = expected_sharp.pop_front();
        if (centre_row !== want.row || centre_col !== want.col ||
            sharp_ch0 !== want.ch0 || sharp_ch1 !== want.ch1 ||
            sharp_ch2 !== want.ch2 || frame_done !== want.done) begin
          report_mismatch($sformatf(
            "got r%0d c%0d %h %h %h d%b, want r%0d c%0d %h %h %h d%b",
            centre_row, centre_col, sharp_ch0, sharp_ch1, sharp_ch2, frame_done,
            want.row, want.col, want.ch0, want.ch1, want.ch2, want.done));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb_sharpen_3x3_laplacian_unit failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_kernel_extremes();
    test_register_clamps();
    test_channel_counts();
    test_midframe_geometry();
    test_widest_rows();
    test_tallest_column();
    test_random_frames();
    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_sharpen_3x3_laplacian_unit passed");
    end else begin
      $display("tb_sharpen_3x3_laplacian_unit failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/shp_pkg.sv
hdl/shp_ram.sv
hdl/shp_lane.sv
hdl/sharpen_3x3_laplacian_unit.sv
test/tb_sharpen_3x3_laplacian_unit.sv
